// ----- hdl/mexp_pkg.sv -----
`default_nettype none

package mexp_pkg;

    // Sequencer states, one-hot.
    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_PRE  = 6'b000010,
        ST_STEP = 6'b000100,
        ST_MUL  = 6'b001000,
        ST_SQR  = 6'b010000,
        ST_DONE = 6'b100000
    } seq_state_t;

    // Kind of modular product that last ran through the cell row.
    typedef enum logic [1:0] {
        KIND_PRE = 2'd0,
        KIND_MUL = 2'd1,
        KIND_SQR = 2'd2
    } mul_kind_t;

    // Register indexes on the configuration port.
    localparam logic CFG_MODULUS  = 1'b0;
    localparam logic CFG_EXPONENT = 1'b1;

    localparam int unsigned CFG_WIDTH = 32;

    // Control broadcast from the sequencer to every cell of the row.
    typedef struct packed {
        logic clear;   // hold the partial remainder at zero
        logic phase;   // 0: double the remainder, 1: add the operand
        logic sub;     // take the reduced value (subtract the modulus)
    } cell_ctl_t;

endpackage

`default_nettype wire

// ----- hdl/mexp_cell.sv -----
`default_nettype none

// One bit slice of the partial remainder of the interleaved modular multiplier.
module mexp_cell
    import mexp_pkg::*;
(
    input  wire logic      aclk,
    input  wire cell_ctl_t ctl,
    input  wire logic      r_low,
    input  wire logic      add_bit,
    input  wire logic      m_bit,
    input  wire logic      c_in,
    input  wire logic      bw_in,
    output logic           r_q,
    output logic           c_out,
    output logic           bw_out
);

    logic r_reg;
    logic r_next;
    logic x_q;
    logic y_bit;

    // Doubling takes the neighbor's bit; adding ripples a carry along the row.
    always_comb begin
        if (ctl.phase) begin
            x_q   = r_reg ^ add_bit ^ c_in;
            c_out = (r_reg & add_bit) | (r_reg & c_in) | (add_bit & c_in);
        end else begin
            x_q   = r_low;
            c_out = 1'b0;
        end
    end

    // Trial subtraction of the modulus bit with a ripple borrow.
    assign y_bit  = x_q ^ m_bit ^ bw_in;
    assign bw_out = (~x_q & m_bit) | (~(x_q ^ m_bit) & bw_in);

    always_comb begin
        if (ctl.clear) begin
            r_next = 1'b0;
        end else if (ctl.sub) begin
            r_next = y_bit;
        end else begin
            r_next = x_q;
        end
    end

    always_ff @(posedge aclk) begin
        r_reg <= r_next;
    end

    assign r_q = r_reg;

endmodule

`default_nettype wire

// ----- hdl/modular_exponentiation.sv -----
`default_nettype none

// Channel   Ports                                   Beat
// -------   -------------------------------------   -----------------------------
// input     s_valid s_ready s_base_value s_final_item   one value to exponentiate
// result    m_valid m_ready m_power_result m_final_result one reduced power
// config    cfg_we cfg_index cfg_wdata              one register write, no wait
//
// One value is worked at a time. Each modular product runs through the row of bit
// cells, one doubling and one addition per bit of the first operand, then through the
// step state; a value needs one reduction product and up to 2*WORD_BITS-2 further
// products. Reset is synchronous, active low, and needs no clearing pass. A new value
// is accepted while the previous result still waits in the output register; the block
// stalls only when a second result is ready.
module modular_exponentiation
    import mexp_pkg::*;
#(
    parameter int unsigned WORD_BITS = 32
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [31:0]          s_base_value,
    input  wire logic                 s_final_item,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic [31:0]               m_power_result,
    output logic                      m_final_result,
    input  wire logic                 cfg_we,
    input  wire logic                 cfg_index,
    input  wire logic [CFG_WIDTH-1:0] cfg_wdata
);

    localparam int unsigned STEPS = 2 * WORD_BITS;
    localparam int unsigned CNT_W = $clog2(STEPS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(STEPS - 1);

    // Configuration registers.
    logic [31:0] mod_cfg_reg;
    logic [31:0] expo_cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mod_cfg_reg  <= 32'd2;
            expo_cfg_reg <= 32'd1;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_MODULUS:  mod_cfg_reg  <= cfg_wdata;
                CFG_EXPONENT: expo_cfg_reg <= cfg_wdata;
                default:      ;
            endcase
        end
    end

    logic [WORD_BITS-1:0] mod_w;
    logic                 mod_nz;
    assign mod_w  = mod_cfg_reg[WORD_BITS-1:0];
    assign mod_nz = |mod_w;

    // Sequencer and operand registers.
    seq_state_t           state_reg, state_next;
    mul_kind_t            kind_reg, kind_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [WORD_BITS-1:0] exp_reg, exp_next;
    logic [WORD_BITS-1:0] acc_reg, acc_next;
    logic                 acc_one_reg, acc_one_next;
    logic [WORD_BITS-1:0] sq_reg, sq_next;
    logic [WORD_BITS-1:0] a_reg, a_next;
    logic [WORD_BITS-1:0] b_reg, b_next;
    logic                 fin_reg, fin_next;
    logic                 m_valid_reg, m_valid_next;
    logic [31:0]          m_power_reg, m_power_next;
    logic                 m_fin_reg, m_fin_next;

    // Row of bit cells.
    cell_ctl_t            ctl;
    logic [WORD_BITS-1:0] r_vec;
    logic [WORD_BITS-1:0] c_vec;
    logic [WORD_BITS-1:0] bw_vec;
    logic                 running;
    logic                 x_top;

    assign running = (state_reg == ST_PRE) || (state_reg == ST_MUL) || (state_reg == ST_SQR);
    assign x_top   = cnt_reg[0] ? c_vec[WORD_BITS-1] : r_vec[WORD_BITS-1];

    always_comb begin
        ctl.clear = !running;
        ctl.phase = cnt_reg[0];
        ctl.sub   = mod_nz && (x_top || !bw_vec[WORD_BITS-1]);
    end

    genvar gi;
    generate
        for (gi = 0; gi < WORD_BITS; gi++) begin : g_cell
            logic r_low;
            logic c_in;
            logic bw_in;
            if (gi == 0) begin : g_first
                assign r_low = 1'b0;
                assign c_in  = 1'b0;
                assign bw_in = 1'b0;
            end else begin : g_rest
                assign r_low = r_vec[gi-1];
                assign c_in  = c_vec[gi-1];
                assign bw_in = bw_vec[gi-1];
            end
            mexp_cell u_cell (
                .aclk    (aclk),
                .ctl     (ctl),
                .r_low   (r_low),
                .add_bit (b_reg[gi] & a_reg[WORD_BITS-1]),
                .m_bit   (mod_w[gi]),
                .c_in    (c_in),
                .bw_in   (bw_in),
                .r_q     (r_vec[gi]),
                .c_out   (c_vec[gi]),
                .bw_out  (bw_vec[gi])
            );
        end
    endgenerate

    assign s_ready = (state_reg == ST_IDLE);

    // Square-and-multiply sequencing over the exponent, lowest bit first.
    always_comb begin
        logic                 need_mul;
        logic [WORD_BITS-1:0] nsq;
        logic [WORD_BITS-1:0] nacc;
        logic                 nacc_one;
        logic [WORD_BITS-1:0] nexp;

        state_next   = state_reg;
        kind_next    = kind_reg;
        cnt_next     = cnt_reg;
        exp_next     = exp_reg;
        acc_next     = acc_reg;
        acc_one_next = acc_one_reg;
        sq_next      = sq_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        fin_next     = fin_reg;
        m_valid_next = m_valid_reg;
        m_power_next = m_power_reg;
        m_fin_next   = m_fin_reg;

        need_mul = 1'b0;
        nsq      = sq_reg;
        nacc     = acc_reg;
        nacc_one = acc_one_reg;
        nexp     = exp_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    a_next       = s_base_value[WORD_BITS-1:0];
                    b_next       = WORD_BITS'(1);
                    exp_next     = expo_cfg_reg[WORD_BITS-1:0];
                    fin_next     = s_final_item;
                    acc_one_next = 1'b1;
                    kind_next    = KIND_PRE;
                    cnt_next     = '0;
                    state_next   = ST_PRE;
                end
            end
            ST_PRE, ST_MUL, ST_SQR: begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg[0]) begin
                    a_next = {a_reg[WORD_BITS-2:0], 1'b0};
                end
                if (cnt_reg == CNT_LAST) begin
                    cnt_next   = '0;
                    state_next = ST_STEP;
                end
            end
            ST_STEP: begin
                case (kind_reg)
                    KIND_MUL: begin
                        nacc     = r_vec;
                        nacc_one = 1'b0;
                    end
                    KIND_SQR: begin
                        nsq  = r_vec;
                        nexp = {1'b0, exp_reg[WORD_BITS-1:1]};
                    end
                    default: begin
                        nsq = r_vec;
                    end
                endcase
                need_mul = (kind_reg != KIND_MUL) && nexp[0];
                if (need_mul && nacc_one) begin
                    nacc     = nsq;
                    nacc_one = 1'b0;
                    need_mul = 1'b0;
                end
                sq_next      = nsq;
                acc_next     = nacc;
                acc_one_next = nacc_one;
                exp_next     = nexp;
                if (need_mul) begin
                    a_next     = nacc;
                    b_next     = nsq;
                    kind_next  = KIND_MUL;
                    state_next = ST_MUL;
                end else if (nexp[WORD_BITS-1:1] == '0) begin
                    state_next = ST_DONE;
                end else begin
                    a_next     = nsq;
                    b_next     = nsq;
                    kind_next  = KIND_SQR;
                    state_next = ST_SQR;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_power_next = acc_one_reg ? 32'd1 : 32'(acc_reg);
                    m_fin_next   = fin_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg    <= kind_next;
        exp_reg     <= exp_next;
        acc_reg     <= acc_next;
        acc_one_reg <= acc_one_next;
        sq_reg      <= sq_next;
        a_reg       <= a_next;
        b_reg       <= b_next;
        fin_reg     <= fin_next;
        m_power_reg <= m_power_next;
        m_fin_reg   <= m_fin_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_power_result = m_power_reg;
    assign m_final_result = m_fin_reg;

    // A finished product is fully reduced whenever the modulus is nonzero.
    a_reduced: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_STEP && mod_nz) |-> (r_vec < mod_w))
        else $error("product not reduced below the modulus");

    // An accepted beat starts the reduction product from a cleared row.
    a_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_PRE && cnt_reg == '0 && r_vec == '0))
        else $error("accepted beat did not start a cleared product");

    // The step cycle always sits on a product boundary.
    a_step_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_STEP) |-> (cnt_reg == '0))
        else $error("step cycle off a product boundary");

    // A result in the done state is delivered once the output register frees up.
    a_deliver: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && !m_valid_reg) |=> (m_valid_reg && state_reg == ST_IDLE))
        else $error("finished result not moved to the output register");

endmodule

`default_nettype wire
